### hdl/preemptive_priority_task_scheduler_defines.svh
// Assertion helpers for the scheduler. Clock aclk, reset aresetn (active low).
`ifndef PREEMPTIVE_PRIORITY_TASK_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication.
`define PTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/pts_pkg.sv
`default_nettype none
package pts_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    // request kinds
    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_RAN      = 3'd2;
    localparam logic [2:0] ST_DONE     = 3'd3;
    localparam logic [2:0] ST_IDLE     = 3'd4;

    typedef struct packed {
        logic [7:0]        prio;
        logic [15:0]       remain;
        logic [7:0]        id;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       burst_len;
        logic [15:0]       wait_cnt;
    } task_t;

    typedef struct packed {
        logic insert;   // place new task in order
        logic tick;     // run head, others wait
        logic pop;      // run head and drop it, rest shift towards head
    } cell_cmd_t;

    // Strict ordering: priority, then remaining, then id, then slot index.
    function automatic logic ranks_ahead(input task_t a, input task_t b);
        return {a.prio, a.remain, a.id, a.slot} < {b.prio, b.remain, b.id, b.slot};
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage
`default_nettype wire

### hdl/pts_cell.sv
`default_nettype none
module pts_cell (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              head,
    input  wire pts_pkg::cell_cmd_t cmd,
    input  wire pts_pkg::task_t    new_task,
    input  wire logic              left_valid,
    input  wire pts_pkg::task_t    left_task,
    input  wire logic              left_before,
    input  wire logic              right_valid,
    input  wire pts_pkg::task_t    right_task,
    output logic                   valid_o,
    output pts_pkg::task_t         task_o,
    output logic                   before_o
);
    import pts_pkg::*;

    logic  valid_reg, valid_next;
    task_t task_reg, task_next;

    // new task goes ahead of this cell (empty cells always lose)
    assign before_o = !valid_reg || ranks_ahead(new_task, task_reg);
    assign valid_o  = valid_reg;
    assign task_o   = task_reg;

    always_comb begin
        valid_next = valid_reg;
        task_next  = task_reg;
        if (cmd.insert) begin
            if (left_before) begin
                valid_next = left_valid;
                task_next  = left_task;
            end else if (before_o) begin
                valid_next = 1'b1;
                task_next  = new_task;
            end
        end else if (cmd.pop) begin
            valid_next         = right_valid;
            task_next          = right_task;
            task_next.wait_cnt = sat_inc(right_task.wait_cnt);
        end else if (cmd.tick && valid_reg) begin
            if (head) begin
                task_next.remain = task_reg.remain - 16'd1;
            end else begin
                task_next.wait_cnt = sat_inc(task_reg.wait_cnt);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        task_reg <= task_next;
    end

endmodule
`default_nettype wire

### hdl/preemptive_priority_task_scheduler.sv
// Channel  | Ports                       | Item
// ---------+-----------------------------+------------------------------------------
// request  | s_tvalid s_tready s_tdata   | arrival (id, priority, burst) or one tick
//          | s_tuser                     |
// result   | m_tvalid m_tready m_tdata   | status, task id, wait, turnaround, time
//          | m_tuser                     |
//
// Each request is first captured into the request registers; then the cell row
// inserts, runs or drops the head task and the result register is loaded.
// A waiting result holds back execution; one further request is still captured,
// then s_tready stays low until the result is taken.
// aresetn is synchronous, active low: empties the row and zeroes the tick count.
// Tasks sit in a row of cells sorted best first, so the head is always the task to run.
`default_nettype none
module preemptive_priority_task_scheduler (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // task_id[7:0], priority_req[15:8], burst[31:16]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // task_id_res[7:0], wait_time[23:8],
                                        // turnaround_time[40:24], current_time[72:41], zero pad
    output logic [2:0]       m_tuser    // status
);
    import pts_pkg::*;

    // captured request
    logic        busy_reg;
    logic        req_reg;
    logic [7:0]  id_reg;
    logic [7:0]  prio_reg;
    logic [15:0] burst_reg;

    // scheduler state outside the row
    logic [31:0]          time_reg;
    logic [MAX_TASKS-1:0] occ_reg, occ_next;   // slot numbers in use

    // result register
    logic        m_tvalid_reg;
    logic [2:0]  status_reg;
    logic [7:0]  res_id_reg;
    logic [15:0] res_wait_reg;
    logic [16:0] res_ta_reg;
    logic [31:0] res_time_reg;

    // cell row
    logic [MAX_TASKS-1:0] valid_vec;
    logic [MAX_TASKS-1:0] before_vec;
    task_t                task_arr [MAX_TASKS];
    task_t                new_task;
    cell_cmd_t            cmd;

    logic              exec;
    logic              full;
    logic              head_done;
    logic [SLOT_W-1:0] free_slot;

    assign s_tready = !busy_reg;
    assign exec     = busy_reg && (!m_tvalid_reg || m_tready);
    assign full     = valid_vec[MAX_TASKS-1];
    assign head_done = valid_vec[0] && (task_arr[0].remain <= 16'd1);

    // lowest free slot number
    always_comb begin
        free_slot = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (!occ_reg[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        new_task.prio      = prio_reg;
        new_task.remain    = (burst_reg == 16'd0) ? 16'd1 : burst_reg;
        new_task.id        = id_reg;
        new_task.slot      = free_slot;
        new_task.burst_len = (burst_reg == 16'd0) ? 16'd1 : burst_reg;
        new_task.wait_cnt  = 16'd0;
    end

    always_comb begin
        cmd.insert = exec && (req_reg == REQ_ARRIVAL) && !full;
        cmd.pop    = exec && (req_reg == REQ_TICK) && head_done;
        cmd.tick   = exec && (req_reg == REQ_TICK) && !head_done;
    end

    always_comb begin
        occ_next = occ_reg;
        if (cmd.insert) begin
            occ_next[free_slot] = 1'b1;
        end else if (cmd.pop) begin
            occ_next[task_arr[0].slot] = 1'b0;
        end
    end

    for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
        logic  lv, lb, rv;
        task_t lt, rt;
        if (g == 0) begin : g_first
            assign lv = 1'b0;
            assign lb = 1'b0;
            assign lt = '0;
        end else begin : g_mid
            assign lv = valid_vec[g-1];
            assign lb = before_vec[g-1];
            assign lt = task_arr[g-1];
        end
        if (g == MAX_TASKS - 1) begin : g_last
            assign rv = 1'b0;
            assign rt = '0;
        end else begin : g_inner
            assign rv = valid_vec[g+1];
            assign rt = task_arr[g+1];
        end
        pts_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .head        (g == 0),
            .cmd         (cmd),
            .new_task    (new_task),
            .left_valid  (lv),
            .left_task   (lt),
            .left_before (lb),
            .right_valid (rv),
            .right_task  (rt),
            .valid_o     (valid_vec[g]),
            .task_o      (task_arr[g]),
            .before_o    (before_vec[g])
        );
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            time_reg     <= '0;
            occ_reg      <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                busy_reg <= 1'b1;
            end else if (exec) begin
                busy_reg <= 1'b0;
            end
            if (exec) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (exec && (req_reg == REQ_TICK)) begin
                time_reg <= time_reg + 32'd1;
            end
            occ_reg <= occ_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            req_reg   <= s_tuser;
            id_reg    <= s_tdata[7:0];
            prio_reg  <= s_tdata[15:8];
            burst_reg <= s_tdata[31:16];
        end
        if (exec) begin
            res_time_reg <= time_reg;
            res_wait_reg <= 16'd0;
            res_ta_reg   <= 17'd0;
            if (req_reg == REQ_ARRIVAL) begin
                status_reg <= full ? ST_FULL : ST_ACCEPTED;
                res_id_reg <= id_reg;
            end else if (!valid_vec[0]) begin
                status_reg <= ST_IDLE;
                res_id_reg <= 8'd0;
            end else if (head_done) begin
                status_reg   <= ST_DONE;
                res_id_reg   <= task_arr[0].id;
                res_wait_reg <= task_arr[0].wait_cnt;
                res_ta_reg   <= 17'(task_arr[0].burst_len) + 17'(task_arr[0].wait_cnt);
            end else begin
                status_reg <= ST_RAN;
                res_id_reg <= task_arr[0].id;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {7'd0, res_time_reg, res_ta_reg, res_wait_reg, res_id_reg};

`include "preemptive_priority_task_scheduler_defines.svh"

    // row stays sorted at the head
    `PTS_ASSERT_NOW(a_head_sorted, valid_vec[1], valid_vec[0] && ranks_ahead(task_arr[0], task_arr[1]), "head cell out of order")
    // occupied cells are packed towards the head
    `PTS_ASSERT_NOW(a_row_packed, 1'b1, ((valid_vec + MAX_TASKS'(1)) & valid_vec) == '0, "gap in cell row")
    // slot map agrees with the number of held tasks
    `PTS_ASSERT_NOW(a_occ_count, 1'b1, $countones(occ_reg) == $countones(valid_vec), "slot map mismatch")
    // a tick advances time by exactly one
    `PTS_ASSERT_NEXT(a_time_step, exec && (req_reg == REQ_TICK), time_reg == $past(time_reg) + 32'd1, "time did not advance")

endmodule
`default_nettype wire
